### design/cyclic_list_cursor_table_macros.svh
// Assertion macros used by the cursor table sequencer.
`ifndef CYCLIC_LIST_CURSOR_TABLE_MACROS_SVH
`define CYCLIC_LIST_CURSOR_TABLE_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define CLCT_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define CLCT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CLCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/clct_pkg.sv
// Types and constants of the cyclic list cursor table.
`timescale 1ns / 1ps

package clct_pkg;

  localparam int VAL_W   = 32;
  localparam int COUNT_W = 5;

  // Operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_NEXT   = 2'd1;
  localparam logic [1:0] OP_PREV   = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] value;
  } req_beat_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] current_value;
    logic [COUNT_W-1:0]      count;
  } rsp_beat_t;

  // Whole-ring command from the sequencer
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTL,
    CELL_SHL,
    CELL_INS
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

  // Where one cell loads from
  typedef enum logic [2:0] {
    SRC_HOLD,
    SRC_RIGHT,
    SRC_LEFT,
    SRC_HEAD,
    SRC_VALUE
  } cell_src_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_ROTATE
  } fsm_state_e;

endpackage

### design/clct_cell.sv
// One storage cell of the ring: holds one entry and loads from a neighbour, the head cell or the request value.
`timescale 1ns / 1ps

module clct_cell (
  input  logic                                clk,
  input  clct_pkg::cell_src_e                 src,
  input  logic signed [clct_pkg::VAL_W-1:0]   right,
  input  logic signed [clct_pkg::VAL_W-1:0]   left,
  input  logic signed [clct_pkg::VAL_W-1:0]   head,
  input  logic signed [clct_pkg::VAL_W-1:0]   value,
  output logic signed [clct_pkg::VAL_W-1:0]   q,
  output logic signed [clct_pkg::VAL_W-1:0]   d
);

  always_comb begin
    unique case (src)
      clct_pkg::SRC_HOLD:  d = q;
      clct_pkg::SRC_RIGHT: d = right;
      clct_pkg::SRC_LEFT:  d = left;
      clct_pkg::SRC_HEAD:  d = head;
      clct_pkg::SRC_VALUE: d = value;
      default:             d = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= d;
  end

endmodule

### design/clct_ctrl.sv
// Sequencer: count, cursor, rotation counter, ring commands and result register.
`timescale 1ns / 1ps
`include "cyclic_list_cursor_table_macros.svh"

module clct_ctrl #(
  parameter int CAPACITY = 16,
  parameter int IDX_W    = $clog2(CAPACITY)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  clct_pkg::req_beat_t                req,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output clct_pkg::rsp_beat_t                rsp,
  output clct_pkg::cell_cmd_t                cmd,
  output logic [IDX_W-1:0]                   tail,
  output logic [IDX_W-1:0]                   ins_pos,
  input  logic signed [clct_pkg::VAL_W-1:0]  head_next
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  clct_pkg::fsm_state_e state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [IDX_W-1:0]     cursor, cursor_next;
  logic [IDX_W-1:0]     rot_left, rot_next;
  clct_pkg::rsp_beat_t  rsp_next;
  logic                 done;
  logic [1:0]           status;

  logic             accept;
  logic             full;
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] cursor_ext;
  logic [CNT_W-1:0] ins_diff;
  logic [CNT_W-1:0] rot_init;

  assign accept     = req_valid && req_ready;
  assign req_ready  = (state == clct_pkg::FSM_IDLE) && (!rsp_valid || rsp_ready);
  assign full       = (count == CNT_W'(CAPACITY));
  assign count_m1   = count - CNT_W'(1);
  assign cursor_ext = CNT_W'(cursor);
  assign ins_diff   = count - cursor_ext;
  assign rot_init   = count - CNT_W'(2);
  assign tail       = count_m1[IDX_W-1:0];
  assign ins_pos    = ins_diff[IDX_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      clct_pkg::FSM_IDLE: begin
        if (accept && req.op == clct_pkg::OP_PREV && count > CNT_W'(2)) begin
          state_next = clct_pkg::FSM_ROTATE;
        end
      end
      clct_pkg::FSM_ROTATE: begin
        if (rot_left == IDX_W'(1)) begin
          state_next = clct_pkg::FSM_IDLE;
        end
      end
    endcase
  end

  // Ring command, bookkeeping and result
  always_comb begin
    cmd.op      = clct_pkg::CELL_HOLD;
    cmd.value   = req.value;
    count_next  = count;
    cursor_next = cursor;
    rot_next    = rot_left;
    done        = 1'b0;
    status      = clct_pkg::STAT_OK;
    unique case (state)
      clct_pkg::FSM_IDLE: begin
        if (accept) begin
          done = 1'b1;
          if (req.op == clct_pkg::OP_APPEND) begin
            if (full) begin
              status = clct_pkg::STAT_FULL;
            end else begin
              cmd.op     = clct_pkg::CELL_INS;
              count_next = count + CNT_W'(1);
            end
          end else if (count == '0) begin
            status = clct_pkg::STAT_EMPTY;
          end else begin
            unique case (req.op)
              clct_pkg::OP_NEXT: begin
                cmd.op      = clct_pkg::CELL_ROTL;
                cursor_next = (cursor_ext + CNT_W'(1) >= count) ? '0 : cursor + IDX_W'(1);
              end
              clct_pkg::OP_PREV: begin
                cursor_next = (cursor == '0) ? count_m1[IDX_W-1:0] : cursor - IDX_W'(1);
                // previous = rotate left count-1 times, one step a cycle
                if (count != CNT_W'(1)) begin
                  cmd.op   = clct_pkg::CELL_ROTL;
                  rot_next = rot_init[IDX_W-1:0];
                  done     = (count == CNT_W'(2));
                end
              end
              clct_pkg::OP_REMOVE: begin
                cmd.op      = clct_pkg::CELL_SHL;
                count_next  = count_m1;
                cursor_next = (cursor_ext >= count_m1) ? '0 : cursor;
              end
              default: begin
                cmd.op = clct_pkg::CELL_HOLD;
              end
            endcase
          end
        end
      end
      clct_pkg::FSM_ROTATE: begin
        cmd.op   = clct_pkg::CELL_ROTL;
        rot_next = rot_left - IDX_W'(1);
        done     = (rot_left == IDX_W'(1));
      end
    endcase
  end

  always_comb begin
    rsp_next.status        = status;
    rsp_next.count         = clct_pkg::COUNT_W'(count_next);
    rsp_next.current_value = (count_next != '0) ? head_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= clct_pkg::FSM_IDLE;
      count     <= '0;
      cursor    <= '0;
      rot_left  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      cursor   <= cursor_next;
      rot_left <= rot_next;
      if (done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp <= rsp_next;
    end
  end

  `CLCT_ASSERT_HOLDS(a_count_bound, count <= CNT_W'(CAPACITY), "count above capacity")
  `CLCT_ASSERT_IMP(a_cursor_empty, count == '0, cursor == '0, "cursor set on empty list")
  `CLCT_ASSERT_IMP(a_cursor_range, count != '0, cursor_ext < count, "cursor past end")
  `CLCT_ASSERT_IMP(a_rotate_blocks, state == clct_pkg::FSM_ROTATE, !req_ready && !done || rot_left == IDX_W'(1), "beat taken mid rotation")
  `CLCT_ASSERT_NEXT(a_full_keeps, accept && req.op == clct_pkg::OP_APPEND && full, count == $past(count), "append on full list changed count")

endmodule

### design/cyclic_list_cursor_table.sv
// Top level: bounded circular list with cursor, built as a ring of cells.
//
//  channel | direction | handshake             | beat
//  req     | in        | req_valid / req_ready | op, value
//  rsp     | out       | rsp_valid / rsp_ready | status, current_value, count
//
// The cells hold the list rotated so the entry under the cursor sits in cell 0.
// Append, next, remove and any step on an empty list complete in the cycle the request is accepted.
// Previous rotates the ring left count-1 times, one step a cycle, and does not rotate
// when a single entry is held.
// The result register frees in the cycle it is taken; req_ready stays low while it is held.
// Synchronous reset empties the list at once; no clearing pass.
`timescale 1ns / 1ps

module cyclic_list_cursor_table #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  clct_pkg::req_beat_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output clct_pkg::rsp_beat_t rsp
);

  localparam int IDX_W = $clog2(CAPACITY);

  clct_pkg::cell_cmd_t             cmd;
  logic [IDX_W-1:0]                tail;
  logic [IDX_W-1:0]                ins_pos;
  logic signed [clct_pkg::VAL_W-1:0] cell_q [CAPACITY];
  logic signed [clct_pkg::VAL_W-1:0] cell_d [CAPACITY];
  clct_pkg::cell_src_e             cell_src [CAPACITY];

  clct_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cmd       (cmd),
    .tail      (tail),
    .ins_pos   (ins_pos),
    .head_next (cell_d[0])
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [IDX_W-1:0] IDX = IDX_W'(i);
    localparam int RI = (i == CAPACITY - 1) ? i : i + 1;
    localparam int LI = (i == 0) ? 0 : i - 1;

    // Cells past the tail hold nothing live, so shifting them is harmless
    always_comb begin
      unique case (cmd.op)
        clct_pkg::CELL_ROTL: begin
          if (IDX < tail) begin
            cell_src[i] = clct_pkg::SRC_RIGHT;
          end else if (IDX == tail) begin
            cell_src[i] = clct_pkg::SRC_HEAD;
          end else begin
            cell_src[i] = clct_pkg::SRC_HOLD;
          end
        end
        clct_pkg::CELL_SHL: begin
          cell_src[i] = clct_pkg::SRC_RIGHT;
        end
        clct_pkg::CELL_INS: begin
          if (IDX == ins_pos) begin
            cell_src[i] = clct_pkg::SRC_VALUE;
          end else if (IDX > ins_pos) begin
            cell_src[i] = clct_pkg::SRC_LEFT;
          end else begin
            cell_src[i] = clct_pkg::SRC_HOLD;
          end
        end
        default: begin
          cell_src[i] = clct_pkg::SRC_HOLD;
        end
      endcase
    end

    clct_cell u_cell (
      .clk   (clk),
      .src   (cell_src[i]),
      .right (cell_q[RI]),
      .left  (cell_q[LI]),
      .head  (cell_q[0]),
      .value (cmd.value),
      .q     (cell_q[i]),
      .d     (cell_d[i])
    );
  end

endmodule
